// ===== rtl/oversample_decimate_average_unit_assert.svh =====
// Assertion macros shared by the averager RTL.
// Each macro expects a clock named clk and a synchronous reset named rst in scope.
`ifndef OVERSAMPLE_DECIMATE_AVERAGE_UNIT_ASSERT_SVH
`define OVERSAMPLE_DECIMATE_AVERAGE_UNIT_ASSERT_SVH

// Condition must never hold outside reset
`define ODA_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define ODA_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/odavg_pkg.sv =====
// Shared types and constants for the oversampling averager.
// No dependencies; imported by every module of the block.
package odavg_pkg;

  localparam int DEF_MAX_TARGET_BITS = 21;
  localparam int DEF_SET_COUNT_BITS  = 16;
  localparam int DEF_FRAC_BITS       = 8;

  // Native converter resolution and its full-scale code
  localparam int BASE_BITS       = 10;
  localparam int FULL_SCALE_BASE = 1023;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_TARGET_BITS = 1'b0,
    REG_SAMPLE_SETS = 1'b1
  } cfg_reg_t;

  // Sequencer states of the top level
  typedef enum logic [0:0] {
    ST_RUN  = 1'b0,
    ST_WAIT = 1'b1
  } state_t;

  // Divider status towards the sequencer
  typedef struct packed {
    logic busy;
    logic finished;
  } div_status_t;

endpackage

// ===== rtl/odavg_accum.sv =====
// Accumulation pipeline: raw sample sum, rounding decimation, set sum.
// Depends on odavg_pkg; feeds odavg_div with the scaled set total.
module odavg_accum import odavg_pkg::*; #(
  parameter int MAX_TARGET_BITS = DEF_MAX_TARGET_BITS,
  parameter int SET_COUNT_BITS  = DEF_SET_COUNT_BITS,
  parameter int FRAC_BITS       = DEF_FRAC_BITS,
  localparam int N_MAX = MAX_TARGET_BITS - BASE_BITS,
  localparam int NW    = $clog2(N_MAX + 2),
  localparam int DIV_W = MAX_TARGET_BITS + SET_COUNT_BITS + FRAC_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      clear,
  input  logic [NW-1:0]             n,
  input  logic [SET_COUNT_BITS-1:0] sets_eff,
  input  logic                      in_fire,
  input  logic [BASE_BITS-1:0]      sample,
  output logic                      close_set,
  output logic                      div_start,
  output logic [DIV_W-1:0]          div_dividend
);

  localparam int IN_W  = BASE_BITS + 2 * N_MAX;
  localparam int CNT_W = 2 * N_MAX + 1;
  localparam int RD_W  = MAX_TARGET_BITS;
  localparam int OUT_W = RD_W + SET_COUNT_BITS;
  localparam int SC    = SET_COUNT_BITS;

  logic [IN_W-1:0]  inner_total;
  logic [CNT_W-1:0] inner_count;
  logic [SC-1:0]    outer_count;
  logic [IN_W-1:0]  grp_sum;
  logic             grp_vld;
  logic             grp_last;
  logic [RD_W-1:0]  reading;
  logic             rd_vld;
  logic             rd_last;
  logic [OUT_W-1:0] outer_total;

  logic [CNT_W:0]   grp_size;
  logic [CNT_W-1:0] grp_top;
  logic             grp_end;
  logic             set_end;
  logic [IN_W-1:0]  raw_sum;
  logic [IN_W:0]    half;
  logic [IN_W:0]    rounded;
  logic [IN_W:0]    shifted;
  logic [OUT_W-1:0] outer_sum;

  // Group of 4^n samples; last count value closes it
  assign grp_size  = {{CNT_W{1'b0}}, 1'b1} << {n, 1'b0};
  assign grp_top   = CNT_W'(grp_size - 1'b1);
  assign grp_end   = (inner_count == grp_top);
  assign set_end   = (outer_count == SC'(sets_eff - 1'b1));
  assign raw_sum   = inner_total + IN_W'(sample);
  assign close_set = in_fire & grp_end & set_end;

  // Round to nearest: add half an LSB of the decimated reading, then drop n bits
  assign half    = (n == '0) ? '0 : ({{IN_W{1'b0}}, 1'b1} << (n - NW'(1)));
  assign rounded = {1'b0, grp_sum} + half;
  assign shifted = rounded >> n;

  assign outer_sum    = outer_total + OUT_W'(reading);
  assign div_start    = rd_vld & rd_last;
  assign div_dividend = DIV_W'(outer_sum) << FRAC_BITS;

  // Control and accumulator state
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      inner_total <= '0;
      inner_count <= '0;
      outer_count <= '0;
      outer_total <= '0;
      grp_vld     <= 1'b0;
      rd_vld      <= 1'b0;
    end else begin
      grp_vld <= in_fire & grp_end;
      rd_vld  <= grp_vld;
      if (in_fire) begin
        if (grp_end) begin
          inner_total <= '0;
          inner_count <= '0;
          outer_count <= set_end ? '0 : outer_count + 1'b1;
        end else begin
          inner_total <= raw_sum;
          inner_count <= inner_count + 1'b1;
        end
      end
      // Fold the reading into the set total; restart it once handed to the divider
      if (rd_vld) begin
        outer_total <= rd_last ? '0 : outer_sum;
      end
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    if (in_fire && grp_end) begin
      grp_sum  <= raw_sum;
      grp_last <= set_end;
    end
    if (grp_vld) begin
      reading <= shifted[RD_W-1:0];
      rd_last <= grp_last;
    end
  end

endmodule

// ===== rtl/odavg_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle from a shared subtractor.
// Depends on odavg_pkg and the assertion macro header.
`include "oversample_decimate_average_unit_assert.svh"

module odavg_div import odavg_pkg::*; #(
  parameter int MAX_TARGET_BITS = DEF_MAX_TARGET_BITS,
  parameter int SET_COUNT_BITS  = DEF_SET_COUNT_BITS,
  parameter int FRAC_BITS       = DEF_FRAC_BITS,
  localparam int DIV_W  = MAX_TARGET_BITS + SET_COUNT_BITS + FRAC_BITS,
  localparam int MEAN_W = MAX_TARGET_BITS + FRAC_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      take,
  input  logic [DIV_W-1:0]          dividend,
  input  logic [SET_COUNT_BITS-1:0] divisor,
  output logic [MEAN_W-1:0]         quotient,
  output div_status_t               status
);

  localparam int SC     = SET_COUNT_BITS;
  localparam int STEP_W = $clog2(DIV_W);

  logic              busy;
  logic              finished;
  logic [STEP_W-1:0] step;
  logic [DIV_W-1:0]  dvd;
  logic [SC-1:0]     rem;
  logic [SC-1:0]     dsr;

  logic [SC:0]       trial;
  logic              ge;
  logic [SC-1:0]     rem_next;

  // Shift in the next dividend bit and try the subtraction
  assign trial    = {rem, dvd[DIV_W-1]};
  assign ge       = (trial >= {1'b0, dsr});
  assign rem_next = ge ? SC'(trial - {1'b0, dsr}) : trial[SC-1:0];

  assign quotient        = dvd[MEAN_W-1:0];
  assign status.busy     = busy;
  assign status.finished = finished;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      finished <= 1'b0;
      step     <= '0;
    end else if (start) begin
      busy     <= 1'b1;
      finished <= 1'b0;
      step     <= '0;
    end else if (busy) begin
      step <= step + 1'b1;
      if (step == STEP_W'(DIV_W - 1)) begin
        busy     <= 1'b0;
        finished <= 1'b1;
      end
    end else if (take) begin
      finished <= 1'b0;
    end
  end

  // Datapath: quotient bits replace dividend bits from the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      dvd <= {dvd[DIV_W-2:0], ge};
      rem <= rem_next;
    end
  end

  `ODA_ASSERT_NEVER(a_busy_and_finished, busy && finished, "divider busy and finished together")
  `ODA_ASSERT_IMPLIES(a_rem_below_divisor, busy, rem < dsr, "partial remainder reached divisor")

endmodule

// ===== rtl/oversample_decimate_average_unit.sv =====
// Oversampling averager: 10-bit converter samples in, mean with fraction bits out.
// Uses the sequencer here, plus the units odavg_accum and odavg_div.
// Channels: input sample on in_valid/in_ready, result (mean_q8, full_scale) on
// out_valid/out_ready. Configuration through wr_en/wr_index/wr_data: index 0 sets
// the target resolution (clamped to 10..MAX_TARGET_BITS), index 1 the number of
// decimated readings per result (zero counts as one). Any write restarts all sums.
// Throughput: one sample per cycle while a set is filling. The sample that closes
// a set drops in_ready until its mean is in the output register: the set total
// passes the group and reading registers and starts the bit-serial divider, which
// produces one quotient bit per cycle over MAX_TARGET_BITS + SET_COUNT_BITS +
// FRAC_BITS bits; the finished quotient is loaded once the output register is free,
// and only after that load is the next sample taken.
// A stalled receiver holds the result in the output register; sampling goes on,
// and only the next set's completion waits for the register to free.
// Reset: resolution 10 bits, one reading per result, all sums cleared, no result.
`include "oversample_decimate_average_unit_assert.svh"

module oversample_decimate_average_unit import odavg_pkg::*; #(
  parameter int MAX_TARGET_BITS = DEF_MAX_TARGET_BITS,
  parameter int SET_COUNT_BITS  = DEF_SET_COUNT_BITS,
  parameter int FRAC_BITS       = DEF_FRAC_BITS,
  localparam int CFG_W = (SET_COUNT_BITS > 5) ? SET_COUNT_BITS : 5
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 wr_en,
  input  logic [0:0]                           wr_index,
  input  logic [CFG_W-1:0]                     wr_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [BASE_BITS-1:0]                 sample,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [MAX_TARGET_BITS+FRAC_BITS-1:0] mean_q8,
  output logic [MAX_TARGET_BITS-1:0]           full_scale
);

  localparam int N_MAX  = MAX_TARGET_BITS - BASE_BITS;
  localparam int NW     = $clog2(N_MAX + 2);
  localparam int SC     = SET_COUNT_BITS;
  localparam int DIV_W  = MAX_TARGET_BITS + SET_COUNT_BITS + FRAC_BITS;
  localparam int MEAN_W = MAX_TARGET_BITS + FRAC_BITS;
  localparam int FS_W   = MAX_TARGET_BITS;

  state_t             state;
  state_t             state_next;
  logic [NW-1:0]      n;
  logic [SC-1:0]      sets;
  logic [SC-1:0]      sets_eff;
  logic [4:0]         tb_raw;
  logic [NW-1:0]      n_wr;
  logic               in_fire;
  logic               take;
  logic               close_set;
  logic               div_start;
  logic [DIV_W-1:0]   div_dividend;
  logic [MEAN_W-1:0]  quotient;
  div_status_t        div_stat;

  assign in_fire  = in_valid & in_ready;
  assign sets_eff = (sets == '0) ? SC'(1) : sets;

  // Clamp a resolution write into range and keep it as the extra bit count
  assign tb_raw = wr_data[4:0];
  always_comb begin
    priority if (tb_raw < 5'(BASE_BITS)) begin
      n_wr = '0;
    end else if (tb_raw > 5'(MAX_TARGET_BITS)) begin
      n_wr = NW'(N_MAX);
    end else begin
      n_wr = NW'(tb_raw - 5'(BASE_BITS));
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      n    <= '0;
      sets <= SC'(1);
    end else if (wr_en) begin
      unique case (cfg_reg_t'(wr_index))
        REG_TARGET_BITS: n    <= n_wr;
        REG_SAMPLE_SETS: sets <= wr_data[SC-1:0];
        default:         n    <= n;
      endcase
    end
  end

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
    end else begin
      state <= state_next;
    end
  end

  // Next state: stop taking samples from a set's close until its mean is loaded into the output register
  always_comb begin
    state_next = state;
    take       = 1'b0;
    in_ready   = 1'b0;
    unique case (state)
      ST_RUN: begin
        in_ready = 1'b1;
        if (close_set) begin
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (div_stat.finished && (!out_valid || out_ready)) begin
          take       = 1'b1;
          state_next = ST_RUN;
        end
      end
      default: state_next = ST_RUN;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      mean_q8    <= quotient;
      full_scale <= FS_W'(FULL_SCALE_BASE) << n;
    end
  end

  odavg_accum #(
    .MAX_TARGET_BITS (MAX_TARGET_BITS),
    .SET_COUNT_BITS  (SET_COUNT_BITS),
    .FRAC_BITS       (FRAC_BITS)
  ) u_accum (
    .clk          (clk),
    .rst          (rst),
    .clear        (wr_en),
    .n            (n),
    .sets_eff     (sets_eff),
    .in_fire      (in_fire),
    .sample       (sample),
    .close_set    (close_set),
    .div_start    (div_start),
    .div_dividend (div_dividend)
  );

  odavg_div #(
    .MAX_TARGET_BITS (MAX_TARGET_BITS),
    .SET_COUNT_BITS  (SET_COUNT_BITS),
    .FRAC_BITS       (FRAC_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .take     (take),
    .dividend (div_dividend),
    .divisor  (sets_eff),
    .quotient (quotient),
    .status   (div_stat)
  );

  `ODA_ASSERT_NEVER(a_ready_while_dividing, in_ready && div_stat.busy, "input ready during divide")
  `ODA_ASSERT_IMPLIES(a_start_in_wait, div_start, state == ST_WAIT, "divide started outside wait")
  `ODA_ASSERT_IMPLIES(a_take_finished, take, div_stat.finished && !div_stat.busy, "early take")

endmodule

// ===== bench/tb_oversample_decimate_average_unit.sv =====
// Self-checking bench for oversample_decimate_average_unit: directed rows, then random phases.
// Depends on odavg_pkg and the RTL of the averager; expected means come from an in-bench predictor.
// Both channels idle at random; one long receiver hold-off forces the input to stall.
module tb_oversample_decimate_average_unit;
  import odavg_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CFG_W     = (DEF_SET_COUNT_BITS > 5) ? DEF_SET_COUNT_BITS : 5;
  localparam int MEAN_W    = DEF_MAX_TARGET_BITS + DEF_FRAC_BITS;
  localparam int FS_W      = DEF_MAX_TARGET_BITS;
  // Pause longer than the result latency at default widths, with a margin
  localparam int LAT_PAUSE = 64;
  // Worst case is under 2k samples plus write pauses; the limit is taken several
  // times over
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int RANDOM_ITEMS = 1000;

  typedef struct packed {
    logic [MEAN_W-1:0] mean;
    logic [FS_W-1:0]   fs;
  } avg_result_t;

  typedef enum logic [0:0] {
    ROW_WRITE  = 1'b0,
    ROW_SAMPLE = 1'b1
  } row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    cfg_reg_t          idx;
    logic [CFG_W-1:0]  data;
    logic [9:0]        s;
    logic              typed;
    avg_result_t       res;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 wr_en = 1'b0;
  logic [0:0]           wr_index = 1'b0;
  logic [CFG_W-1:0]     wr_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [BASE_BITS-1:0] sample = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [MEAN_W-1:0]    mean_q8;
  logic [FS_W-1:0]      full_scale;

  oversample_decimate_average_unit DUT (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sample     (sample),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .mean_q8    (mean_q8),
    .full_scale (full_scale)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Predictor state and configuration
  int unsigned       pred_target;
  logic [15:0]       pred_sets;
  logic [63:0]       pred_raw_sum;
  int unsigned       pred_raw_cnt;
  logic [63:0]       pred_dec_sum;
  int unsigned       pred_dec_cnt;

  avg_result_t       pending_means[$];
  stim_row_t         dir_rows[$];

  int unsigned       cycle_count = 0;
  int                mismatch_count = 0;
  int                means_checked = 0;
  int                samples_sent = 0;
  int                phases_run = 0;
  int                nogap_left = 0;

  function automatic void clear_sums();
    pred_raw_sum = '0;
    pred_raw_cnt = 0;
    pred_dec_sum = '0;
    pred_dec_cnt = 0;
  endfunction

  // Mirror a register write: clamp the resolution, drop wide count bits, restart sums
  function automatic void apply_reg_write(input cfg_reg_t idx, input logic [CFG_W-1:0] data);
    int unsigned v;
    if (idx == REG_TARGET_BITS) begin
      v = data[4:0];
      if (v < BASE_BITS) v = BASE_BITS;
      if (v > DEF_MAX_TARGET_BITS) v = DEF_MAX_TARGET_BITS;
      pred_target = v;
    end else begin
      pred_sets = data[DEF_SET_COUNT_BITS-1:0];
    end
    clear_sums();
  endfunction

  // Accumulate one sample; return 1 with the mean when a set of readings closes
  function automatic bit decimate_step(input logic [9:0] s, output avg_result_t res);
    int unsigned n;
    int unsigned group;
    int unsigned sets;
    logic [63:0] half;
    logic [63:0] reading;
    logic [63:0] scaled;
    res = '0;
    n = pred_target - BASE_BITS;
    group = 1 << (2 * n);
    sets = (pred_sets == 0) ? 1 : pred_sets;
    half = (n == 0) ? 64'd0 : (64'd1 << (n - 1));
    pred_raw_sum = pred_raw_sum + 64'(s);
    pred_raw_cnt++;
    if (pred_raw_cnt < group) return 1'b0;
    reading = (pred_raw_sum + half) >> n;
    pred_raw_sum = '0;
    pred_raw_cnt = 0;
    pred_dec_sum = pred_dec_sum + reading;
    pred_dec_cnt++;
    if (pred_dec_cnt < sets) return 1'b0;
    scaled = (pred_dec_sum << DEF_FRAC_BITS) / 64'(sets);
    res.mean = scaled[MEAN_W-1:0];
    res.fs = FS_W'(64'(FULL_SCALE_BASE) << n);
    pred_dec_sum = '0;
    pred_dec_cnt = 0;
    return 1'b1;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [9:0] rand_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 10'd0;
    if (r == 1) return 10'd1023;
    if (r == 2) return 10'(1 << $urandom_range(0, 9));
    return 10'($urandom_range(0, 1023));
  endfunction

  function automatic stim_row_t row_wr(input cfg_reg_t idx, input logic [CFG_W-1:0] data);
    stim_row_t r;
    r = '0;
    r.kind = ROW_WRITE;
    r.idx = idx;
    r.data = data;
    return r;
  endfunction

  function automatic stim_row_t row_smp(input logic [9:0] s);
    stim_row_t r;
    r = '0;
    r.kind = ROW_SAMPLE;
    r.s = s;
    return r;
  endfunction

  function automatic stim_row_t row_chk(input logic [9:0] s, input logic [MEAN_W-1:0] mean,
                                        input logic [FS_W-1:0] fs);
    stim_row_t r;
    r = row_smp(s);
    r.typed = 1'b1;
    r.res.mean = mean;
    r.res.fs = fs;
    return r;
  endfunction

  // Wait for the block to drain, let the divider settle, then write one register
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] data);
    in_valid <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk);
    repeat (LAT_PAUSE) @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= data;
    @(posedge clk);
    apply_reg_write(idx, data);
    wr_en <= 1'b0;
  endtask

  // Offer one sample after a random gap; hold it until the transaction completes
  task automatic push_sample(input logic [9:0] s, input bit typed, input avg_result_t typed_res);
    int g;
    avg_result_t res;
    if (nogap_left > 0) begin
      nogap_left--;
      g = 0;
    end else begin
      if ($urandom_range(0, 19) == 0) nogap_left = $urandom_range(50, 200);
      g = pick_gap();
    end
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample <= s;
    do @(posedge clk); while (!in_ready);
    samples_sent++;
    if (decimate_step(s, res)) pending_means.push_back(typed ? typed_res : res);
  endtask

  // Set both registers, then feed the given number of random samples
  task automatic run_phase(input int target, input logic [CFG_W-1:0] sets_data, input int count);
    logic [CFG_W-1:0] tdata;
    tdata = CFG_W'($urandom_range(0, (1 << CFG_W) - 1));
    tdata[4:0] = 5'(target);
    write_reg(REG_TARGET_BITS, tdata);
    write_reg(REG_SAMPLE_SETS, sets_data);
    for (int i = 0; i < count; i++) push_sample(rand_sample(), 1'b0, '0);
    phases_run++;
  endtask

  // Check each completed result against the oldest expectation
  always @(posedge clk) begin
    avg_result_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_means.size() == 0) begin
        $error("unexpected result: mean_q8=%0d full_scale=%0d", mean_q8, full_scale);
        mismatch_count++;
      end else begin
        e = pending_means.pop_front();
        if (mean_q8 !== e.mean) begin
          $error("mean_q8: expected %0d, got %0d", e.mean, mean_q8);
          mismatch_count++;
        end
        if (full_scale !== e.fs) begin
          $error("full_scale: expected %0d, got %0d", e.fs, full_scale);
          mismatch_count++;
        end
        means_checked++;
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_means.size());
      $display("tb_oversample_decimate_average_unit: done, errors");
      $finish;
    end
  end

  // Receiver: random ready with gaps, plus one long hold-off to back the block up
  initial begin
    bit held;
    int run;
    int g;
    held = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (!held && means_checked >= 30) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        run = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 12);
        repeat (run) @(posedge clk);
        g = pick_gap();
        if (g > 0) begin
          out_ready <= 1'b0;
          repeat (g) @(posedge clk);
        end
      end
    end
  end

  // Stimulus
  initial begin
    int rand_items;
    int target;
    int r;
    int n;
    int unsigned per;
    int count;
    logic [CFG_W-1:0] sets_data;
    logic [CFG_W-1:0] tdata;

    pred_target = BASE_BITS;
    pred_sets = 16'd1;
    clear_sums();

    // Reset state: 10 bits, one reading per result
    dir_rows.push_back(row_chk(10'd0, 29'd0, 21'd1023));
    dir_rows.push_back(row_chk(10'd1023, 29'd261888, 21'd1023));
    dir_rows.push_back(row_smp(10'h2AA));
    // A set count of zero behaves as one
    dir_rows.push_back(row_wr(REG_SAMPLE_SETS, 16'd0));
    dir_rows.push_back(row_chk(10'd1023, 29'd261888, 21'd1023));
    // Resolution below range clamps to 10
    dir_rows.push_back(row_wr(REG_TARGET_BITS, 16'd5));
    dir_rows.push_back(row_chk(10'd1, 29'd256, 21'd1023));
    // 11 bits: four samples per reading, full scale doubles
    dir_rows.push_back(row_wr(REG_TARGET_BITS, 16'd11));
    repeat (3) dir_rows.push_back(row_smp(10'd1023));
    dir_rows.push_back(row_chk(10'd1023, 29'd523776, 21'd2046));
    // Rounding: a sum of one rounds up to one
    dir_rows.push_back(row_smp(10'd1));
    repeat (3) dir_rows.push_back(row_smp(10'd0));
    // Resolution above range clamps to 21; a partial group is then dropped by the next write
    dir_rows.push_back(row_wr(REG_TARGET_BITS, 16'd31));
    dir_rows.push_back(row_smp(10'd1023));
    // Upper data bits are ignored for the resolution register
    dir_rows.push_back(row_wr(REG_TARGET_BITS, 16'hFFEB));
    repeat (3) dir_rows.push_back(row_smp(10'd0));
    dir_rows.push_back(row_chk(10'd0, 29'd0, 21'd2046));
    // Truncated mean over three readings
    dir_rows.push_back(row_wr(REG_TARGET_BITS, 16'd10));
    dir_rows.push_back(row_wr(REG_SAMPLE_SETS, 16'd3));
    dir_rows.push_back(row_smp(10'd1));
    dir_rows.push_back(row_smp(10'd1));
    dir_rows.push_back(row_smp(10'd2));
    // A write in the middle of a set discards it
    dir_rows.push_back(row_smp(10'd1023));
    dir_rows.push_back(row_smp(10'd1023));
    dir_rows.push_back(row_wr(REG_SAMPLE_SETS, 16'd2));
    repeat (2) dir_rows.push_back(row_smp(10'd0));

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_WRITE) write_reg(dir_rows[i].idx, dir_rows[i].data);
      else push_sample(dir_rows[i].s, dir_rows[i].typed, dir_rows[i].res);
    end

    // Fast phase first, so the receiver hold-off lands while every sample closes a set
    run_phase(10, 16'd1, 120);
    rand_items = 120;

    // Random phases at small resolutions and set counts
    while (rand_items < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 50) target = 10;
      else if (r < 80) target = 11;
      else if (r < 95) target = 12;
      else target = 13;
      if ($urandom_range(0, 9) == 0) sets_data = '0;
      else if (target == 13) sets_data = CFG_W'(1);
      else sets_data = CFG_W'($urandom_range(1, 4));
      n = target - BASE_BITS;
      per = (1 << (2 * n)) * ((sets_data == 0) ? 1 : sets_data);
      if (per >= 16) count = per * $urandom_range(1, 4) + $urandom_range(0, per - 1);
      else count = per * $urandom_range(8, 40) + $urandom_range(0, per - 1);
      // Resolution 10 is sometimes reached through a clamped low write
      if (target == 10 && $urandom_range(0, 1) == 0) target = $urandom_range(0, 9);
      run_phase(target, sets_data, count);
      rand_items += count;
    end

    // Top resolution: write it directly and by clamping, feed a partial group only
    run_phase(21, 16'd1, 40);
    tdata = CFG_W'($urandom_range(0, (1 << CFG_W) - 1));
    tdata[4:0] = 5'($urandom_range(22, 31));
    write_reg(REG_TARGET_BITS, tdata);
    for (int i = 0; i < 30; i++) push_sample(rand_sample(), 1'b0, '0);

    // 14 bits, one reading per result: one result and a tail
    run_phase(14, 16'd1, 256 + 40);

    // Largest set count at base resolution: a partial set only
    run_phase(10, 16'hFFFF, 40);

    in_valid <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk);
    repeat (LAT_PAUSE) @(posedge clk);

    $display("covered %0d samples over %0d random phases, %0d results compared", samples_sent,
             phases_run, means_checked);
    $display("resolutions 10 to 21 bits with clamped writes, set counts 0 to 65535");
    if (mismatch_count == 0) begin
      $display("tb_oversample_decimate_average_unit: done, clean");
    end else begin
      $display("tb_oversample_decimate_average_unit: done, errors");
    end
    $finish;
  end

endmodule
